// ----- sv/fsra_pkg.sv -----
`default_nettype none

package fsra_pkg;

  localparam int unsigned DIV_STEPS = 30;
  localparam int unsigned NEST_CNT  = 5;
  localparam int unsigned NEST_STG  = 2 * NEST_CNT;
  localparam int unsigned NSTG      = 6 + DIV_STEPS + 4 + NEST_STG + 2;

  localparam logic [63:0] ONE23 = 64'd1 << 23;
  localparam logic [63:0] ONE29 = 64'd1 << 29;
  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] ONE31 = 64'd1 << 31;

  localparam logic [63:0] QB0 = 64'd2 << 24;
  localparam logic [63:0] QB1 = ((64'd2524 << 24) + 64'd500) / 64'd1000;
  localparam logic [63:0] QB2 = ((64'd1886 << 24) + 64'd500) / 64'd1000;
  localparam logic [63:0] QB3 = ((64'd803 << 24) + 64'd500) / 64'd1000;
  localparam logic [63:0] QC0 = 64'd1 << 24;
  localparam logic [63:0] QC1 = ((64'd506 << 24) + 64'd500) / 64'd1000;
  localparam logic [63:0] QD0 =
    ((64'd141421356237 << 24) + 64'd50000000000) / 64'd100000000000;
  localparam logic [63:0] QD1 = ((64'd2054 << 24) + 64'd500) / 64'd1000;
  localparam logic [63:0] QD2 = ((64'd1790 << 24) + 64'd500) / 64'd1000;
  localparam logic [63:0] K_S2P =
    ((64'd7978845608 << 30) + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] K_SP2 =
    ((64'd12533141373 << 30) + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] K_SP8 =
    ((64'd6266570687 << 30) + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] K_PIH =
    ((64'd15707963268 << 30) + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] K_2PI = 64'd4 * K_PIH;

  localparam int unsigned COS_N [NEST_CNT] = '{90, 56, 30, 12, 2};
  localparam int unsigned COS_L [NEST_CNT] = '{7, 6, 5, 4, 1};
  localparam int unsigned SIN_N [NEST_CNT] = '{110, 72, 42, 20, 6};
  localparam int unsigned SIN_L [NEST_CNT] = '{7, 7, 6, 5, 3};

  typedef struct packed {
    logic [44:0] rem;
    logic [29:0] qs;
    logic [44:0] dv;
  } fsra_div_t;

  typedef struct packed {
    logic [29:0] u;
    logic [30:0] h;
  } fsra_nest_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] t2q;
  } fsra_mid_t;

  typedef struct packed {
    logic        neg;
    logic [29:0] rr;
    logic [29:0] th;
    logic [1:0]  quad;
    logic        swap;
  } fsra_tail_t;

endpackage

`default_nettype wire

// ----- sv/fsra_if.sv -----
`default_nettype none

interface fsra_arg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;
  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

interface fsra_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fresnel_result;
  modport source (output valid, output fresnel_result, input ready);
  modport sink (input valid, input fresnel_result, output ready);
endinterface

`default_nettype wire

// ----- sv/fresnel_sine_rational_approx.sv -----
// channel  | dir | payload                     | beat
// arg      | in  | x_value, s32 q8.24          | valid & ready
// result   | out | fresnel_result, s32 q1.30   | valid & ready
//
// one beat per cycle sustained while the output buffer has room
// pipe depth set by the 30-cell divider rows and the 5-cell taylor rows
// rst is synchronous and clears the stage valids and the output buffer
// a two-entry output buffer takes results; the whole pipe holds while it is full
`default_nettype none

module fresnel_sine_rational_approx import fsra_pkg::*; (
  input logic        clk,
  input logic        rst,
  fsra_arg_if.sink   arg,
  fsra_res_if.source result
);

  logic            en;
  logic [NSTG-1:0] vld;
  logic [1:0]      cnt;
  logic            wp;
  logic            rp;
  logic [31:0]     fifo [2];
  logic            push;
  logic            pop;

  logic        neg1;
  logic [31:0] ax1;
  logic        neg2;
  logic [30:0] t2;
  logic        neg3;
  logic [30:0] t3;
  logic [31:0] b1_3;
  logic [30:0] c3;
  logic [31:0] d1_3;
  logic [31:0] t2q3;
  logic        neg4;
  logic [30:0] t4;
  logic [37:0] b2_4;
  logic [30:0] c4;
  logic [38:0] d4;
  logic [31:0] t2q4;
  logic        neg5;
  logic [30:0] t5;
  logic [30:0] blo5;
  logic [13:0] bhi5;
  logic [31:0] rhi5;
  logic [29:0] rlo5;
  logic [38:0] d5;
  logic [31:0] t2q5;
  logic        neg6;
  logic [43:0] b6;
  logic [31:0] rhi6;
  logic [29:0] rlo6;
  logic [38:0] d6;
  logic [31:0] t2q6;

  fsra_div_t  inv_c [DIV_STEPS+1];
  fsra_div_t  rat_c [DIV_STEPS+1];
  fsra_mid_t  mid_c [DIV_STEPS+1];

  logic        neg7;
  logic [31:0] phase7;
  logic [29:0] rr7;
  logic        neg8;
  logic [1:0]  quad8;
  logic        swap8;
  logic [29:0] g8;
  logic [29:0] rr8;
  logic        neg9;
  logic [1:0]  quad9;
  logic        swap9;
  logic [29:0] th9;
  logic [29:0] rr9;
  logic [29:0] u10;
  fsra_tail_t  tail10;

  fsra_nest_t  cn [NEST_CNT+1];
  fsra_nest_t  sn [NEST_CNT+1];
  fsra_tail_t  tail_c [NEST_STG+1];

  logic        neg11;
  logic        cneg11;
  logic [29:0] rr11;
  logic [30:0] cmag11;
  logic        neg12;
  logic        cneg12;
  logic [30:0] m12;

  logic [29:0] r8;
  logic        swap_n;
  logic [30:0] sg;
  logic [31:0] mag;
  logic [31:0] res;

  assign en        = ~cnt[1];
  assign arg.ready = en;
  assign push      = en & vld[NSTG-1];
  assign pop       = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], arg.valid};
    end
  end

  // front: magnitude, t, horner terms
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= arg.x_value[31];
      ax1  <= arg.x_value[31] ? (32'd0 - $unsigned(arg.x_value)) : $unsigned(arg.x_value);

      neg2 <= neg1;
      t2   <= 31'((64'(ax1) * K_S2P + ONE29) >> 30);

      neg3 <= neg2;
      t3   <= t2;
      b1_3 <= 32'(QB2 + ((64'(t2) * QB3 + ONE23) >> 24));
      c3   <= 31'(QC0 + ((64'(t2) * QC1 + ONE23) >> 24));
      d1_3 <= 32'(QD1 + ((64'(t2) * QD2 + ONE23) >> 24));
      t2q3 <= 32'((64'(t2) * 64'(t2) + (64'd1 << 17)) >> 18);

      neg4 <= neg3;
      t4   <= t3;
      b2_4 <= 38'(QB1 + ((64'(t3) * 64'(b1_3) + ONE23) >> 24));
      c4   <= c3;
      d4   <= 39'(QD0 + ((64'(t3) * 64'(d1_3) + ONE23) >> 24));
      t2q4 <= t2q3;

      neg5 <= neg4;
      t5   <= t4;
      blo5 <= 31'((64'(t4) * 64'(b2_4[23:0]) + ONE23) >> 24);
      bhi5 <= b2_4[37:24];
      rhi5 <= 32'(64'(c4) + 64'(d4[38:31]));
      rlo5 <= d4[30:1];
      d5   <= d4;
      t2q5 <= t2q4;

      neg6 <= neg5;
      b6   <= 44'(QB0 + 64'(t5) * 64'(bhi5) + 64'(blo5));
      rhi6 <= rhi5;
      rlo6 <= rlo5;
      d6   <= d5;
      t2q6 <= t2q5;
    end
  end

  // divider rows: 2^54/b and c*2^30/d, both rounded
  always_comb begin
    inv_c[0].rem = 45'(64'd1 << 24) + 45'(b6[43:31]);
    inv_c[0].qs  = b6[30:1];
    inv_c[0].dv  = 45'(b6);
    rat_c[0].rem = 45'(rhi6);
    rat_c[0].qs  = rlo6;
    rat_c[0].dv  = 45'(d6);
    mid_c[0].neg = neg6;
    mid_c[0].t2q = t2q6;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fsra_div_cell u_inv (.clk(clk), .en(en), .d_in(inv_c[i]), .d_out(inv_c[i+1]));
    fsra_div_cell u_rat (.clk(clk), .en(en), .d_in(rat_c[i]), .d_out(rat_c[i+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        mid_c[i+1] <= mid_c[i];
      end
    end
  end

  // phase, cosine folding, theta and u
  always_comb begin
    r8     = phase7[29:0];
    swap_n = r8 > 30'(ONE29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg7   <= mid_c[DIV_STEPS].neg;
      phase7 <= {2'b00, inv_c[DIV_STEPS].qs} - mid_c[DIV_STEPS].t2q;
      rr7    <= 30'((64'(rat_c[DIV_STEPS].qs) * K_SP2 + ONE29) >> 30);

      neg8  <= neg7;
      quad8 <= phase7[31:30];
      swap8 <= swap_n;
      g8    <= swap_n ? 30'(31'(ONE30) - {1'b0, r8}) : r8;
      rr8   <= rr7;

      neg9  <= neg8;
      quad9 <= quad8;
      swap9 <= swap8;
      th9   <= 30'((64'(g8) * K_2PI + ONE31) >> 32);
      rr9   <= rr8;

      u10         <= 30'((64'(th9) * 64'(th9) + ONE29) >> 30);
      tail10.neg  <= neg9;
      tail10.rr   <= rr9;
      tail10.th   <= th9;
      tail10.quad <= quad9;
      tail10.swap <= swap9;
    end
  end

  // taylor rows for cosine and sine
  always_comb begin
    cn[0].u   = u10;
    cn[0].h   = 31'(ONE30);
    sn[0].u   = u10;
    sn[0].h   = 31'(ONE30);
    tail_c[0] = tail10;
  end

  for (genvar i = 0; i < NEST_CNT; i++) begin : g_nest
    localparam logic [36:0] CB = 37'(64'(COS_N[i]) << 29);
    localparam logic [31:0] CM =
      32'(((64'd1 << (30 + COS_L[i])) + 64'(COS_N[i]) - 64'd1) / 64'(COS_N[i]));
    localparam logic [5:0]  CS = 6'(30 + COS_L[i]);
    localparam logic [36:0] SB = 37'(64'(SIN_N[i]) << 29);
    localparam logic [31:0] SM =
      32'(((64'd1 << (30 + SIN_L[i])) + 64'(SIN_N[i]) - 64'd1) / 64'(SIN_N[i]));
    localparam logic [5:0]  SS = 6'(30 + SIN_L[i]);

    fsra_nest_cell u_cos (
      .clk(clk), .en(en), .n_in(cn[i]), .bias(CB), .mult(CM), .sh(CS), .n_out(cn[i+1])
    );
    fsra_nest_cell u_sin (
      .clk(clk), .en(en), .n_in(sn[i]), .bias(SB), .mult(SM), .sh(SS), .n_out(sn[i+1])
    );
  end

  for (genvar i = 0; i < NEST_STG; i++) begin : g_tail
    always_ff @(posedge clk) begin
      if (en) begin
        tail_c[i+1] <= tail_c[i];
      end
    end
  end

  // quadrant select, scale, combine
  always_comb begin
    sg  = 31'((64'(tail_c[NEST_STG].th) * 64'(sn[NEST_CNT].h) + ONE29) >> 30);
    mag = cneg12 ? (32'(K_SP8) + 32'(m12)) : (32'(K_SP8) - 32'(m12));
    res = neg12 ? (32'd0 - mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg11  <= tail_c[NEST_STG].neg;
      cneg11 <= tail_c[NEST_STG].quad[1] ^ tail_c[NEST_STG].quad[0];
      rr11   <= tail_c[NEST_STG].rr;
      cmag11 <= (tail_c[NEST_STG].quad[0] ^ tail_c[NEST_STG].swap) ? sg : cn[NEST_CNT].h;

      neg12  <= neg11;
      cneg12 <= cneg11;
      m12    <= 31'((64'(rr11) * 64'(cmag11) + ONE29) >> 30);
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

  assign result.valid          = cnt != 2'd0;
  assign result.fresnel_result = $signed(fifo[rp]);

endmodule

`default_nettype wire

// ----- sv/fsra_div_cell.sv -----
`default_nettype none

module fsra_div_cell import fsra_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  fsra_div_t d_in,
  output fsra_div_t d_out
);

  logic [45:0] trial;
  logic [45:0] diff;
  logic        ge;
  fsra_div_t   d_next;

  always_comb begin
    trial  = {d_in.rem, d_in.qs[29]};
    diff   = trial - {1'b0, d_in.dv};
    ge     = trial >= {1'b0, d_in.dv};
    d_next.rem = ge ? diff[44:0] : trial[44:0];
    d_next.qs  = {d_in.qs[28:0], ge};
    d_next.dv  = d_in.dv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fsra_nest_cell.sv -----
`default_nettype none

module fsra_nest_cell import fsra_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  fsra_nest_t  n_in,
  input  logic [36:0] bias,
  input  logic [31:0] mult,
  input  logic [5:0]  sh,
  output fsra_nest_t  n_out
);

  logic [61:0] x_sum;
  logic [61:0] q_prod;
  logic [29:0] y;
  logic [29:0] u_d;
  logic [29:0] q;

  always_comb begin
    x_sum  = 62'(n_in.u) * 62'(n_in.h) + 62'(bias);
    q_prod = 62'(y) * 62'(mult);
    q      = 30'(q_prod >> sh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y       <= x_sum[59:30];
      u_d     <= n_in.u;
      n_out.u <= u_d;
      n_out.h <= 31'(ONE30) - {1'b0, q};
    end
  end

endmodule

`default_nettype wire

// ----- sv/fsra_checker.sv -----
`default_nettype none

module fsra_checker (
  input logic        clk,
  input logic        rst,
  input logic        arg_valid,
  input logic        arg_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_data
);

  // stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> arg_ready)
    else $error("argument refused with empty output buffer");

  a_ready_after_take: assert property (@(posedge clk) disable iff (rst)
    res_ready && !$past(rst) |=> arg_ready)
    else $error("argument refused after result side was ready");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    arg_valid && !arg_ready |-> res_valid)
    else $error("argument stalled without pending result");

endmodule

bind fresnel_sine_rational_approx fsra_checker u_fsra_checker (
  .clk       (clk),
  .rst       (rst),
  .arg_valid (arg.valid),
  .arg_ready (arg.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.fresnel_result)
);

`default_nettype wire
